// ===== src/kwm_pkg.sv =====
package kwm_pkg;

    localparam int BASE_W     = 2;
    localparam int KMER_W     = 62;
    localparam int KLEN_W     = 5;
    localparam int WIN_W      = 7;
    localparam int CFG_DATA_W = 7;
    localparam int REG_IDX_W  = 1;
    localparam int FILL_W     = 8;
    localparam int IN_TDATA_W = 8;

    localparam logic [FILL_W-1:0] FILL_CAP = 8'd255;

    localparam logic [REG_IDX_W-1:0] REG_KMER_LENGTH = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_SIZE = 1'b1;

    localparam logic [KLEN_W-1:0] KLEN_RESET = 5'd15;
    localparam logic [WIN_W-1:0]  WIN_RESET  = 7'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HASH,
        ST_PUSH,
        ST_EXPIRE,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        HS_ADD21,
        HS_XOR24,
        HS_ADD3_8,
        HS_XOR14,
        HS_ADD2_4,
        HS_XOR28,
        HS_ADD31
    } hash_step_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD_NEW,
        CELL_TAKE_NEXT,
        CELL_EMPTY
    } cell_sel_t;

    typedef struct packed {
        logic clear;
        logic push;
        logic shift;
    } queue_ctrl_t;

    typedef struct packed {
        logic head_valid;
        logic head_expired;
    } queue_status_t;

    // one round of the invertible integer mix, all values kept under mask m
    function automatic logic [KMER_W-1:0] hash_step(
        input logic [KMER_W-1:0] key,
        input logic [KMER_W-1:0] m,
        input hash_step_t        step
    );
        logic [KMER_W-1:0] r;
        case (step)
            HS_ADD21:  r = (~key + (key << 21)) & m;
            HS_XOR24:  r = key ^ (key >> 24);
            HS_ADD3_8: r = (key + (key << 3) + (key << 8)) & m;
            HS_XOR14:  r = key ^ (key >> 14);
            HS_ADD2_4: r = (key + (key << 2) + (key << 4)) & m;
            HS_XOR28:  r = key ^ (key >> 28);
            HS_ADD31:  r = (key + (key << 31)) & m;
            default:   r = key;
        endcase
        return r;
    endfunction

endpackage

// ===== src/kwm_hash.sv =====
module kwm_hash (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [kwm_pkg::KMER_W-1:0] key,
    input  logic [kwm_pkg::KMER_W-1:0] mask,
    output logic [kwm_pkg::KMER_W-1:0] result,
    output logic                      done
);
    import kwm_pkg::*;

    logic [KMER_W-1:0] key_reg;
    hash_step_t        step_reg;
    logic              run_reg;
    logic              done_reg;

    // one mix round per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= HS_ADD21;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= HS_ADD21;
            end
            else if (run_reg)
            begin
                step_reg <= hash_step_t'(step_reg + 3'd1);
                if (step_reg == HS_ADD31)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            key_reg <= key;
        else if (run_reg)
            key_reg <= hash_step(key_reg, mask, step_reg);
    end

    assign result = key_reg;
    assign done   = done_reg;

endmodule

// ===== src/kwm_cell.sv =====
module kwm_cell #(
    parameter int POS_W = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  kwm_pkg::cell_sel_t         sel,
    input  logic [kwm_pkg::KMER_W-1:0] new_hash,
    input  logic [POS_W-1:0]           new_pos,
    input  logic [kwm_pkg::KMER_W-1:0] new_kmer,
    input  logic [kwm_pkg::KMER_W-1:0] next_hash,
    input  logic [POS_W-1:0]           next_pos,
    input  logic [kwm_pkg::KMER_W-1:0] next_kmer,
    input  logic                       next_valid,
    output logic [kwm_pkg::KMER_W-1:0] cell_hash,
    output logic [POS_W-1:0]           cell_pos,
    output logic [kwm_pkg::KMER_W-1:0] cell_kmer,
    output logic                       cell_valid,
    output logic                       hash_le
);
    import kwm_pkg::*;

    logic [KMER_W-1:0] hash_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [KMER_W-1:0] kmer_reg;
    logic              valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
        begin
            case (sel)
                CELL_LOAD_NEW:  valid_reg <= 1'b1;
                CELL_TAKE_NEXT: valid_reg <= next_valid;
                CELL_EMPTY:     valid_reg <= 1'b0;
                default:        valid_reg <= valid_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (sel)
            CELL_LOAD_NEW:
            begin
                hash_reg <= new_hash;
                pos_reg  <= new_pos;
                kmer_reg <= new_kmer;
            end
            CELL_TAKE_NEXT:
            begin
                hash_reg <= next_hash;
                pos_reg  <= next_pos;
                kmer_reg <= next_kmer;
            end
            default:
            begin
                hash_reg <= hash_reg;
                pos_reg  <= pos_reg;
                kmer_reg <= kmer_reg;
            end
        endcase
    end

    // incoming hash pops this entry when it is not larger
    assign hash_le    = new_hash <= hash_reg;
    assign cell_hash  = hash_reg;
    assign cell_pos   = pos_reg;
    assign cell_kmer  = kmer_reg;
    assign cell_valid = valid_reg;

endmodule

// ===== src/kwm_queue.sv =====
module kwm_queue #(
    parameter int MAX_WINDOW = 64,
    parameter int POS_W      = 32,
    parameter int WEFF_W     = 9
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  kwm_pkg::queue_ctrl_t       ctrl,
    input  logic [kwm_pkg::KMER_W-1:0] new_hash,
    input  logic [POS_W-1:0]           new_pos,
    input  logic [kwm_pkg::KMER_W-1:0] new_kmer,
    input  logic [WEFF_W-1:0]          win,
    output logic [POS_W-1:0]           head_pos,
    output logic [kwm_pkg::KMER_W-1:0] head_kmer,
    output kwm_pkg::queue_status_t     status
);
    import kwm_pkg::*;

    logic [KMER_W-1:0]     hash_q [MAX_WINDOW];
    logic [POS_W-1:0]      pos_q  [MAX_WINDOW];
    logic [KMER_W-1:0]     kmer_q [MAX_WINDOW];
    logic [MAX_WINDOW-1:0] valid_q;
    logic [MAX_WINDOW-1:0] le;
    logic [MAX_WINDOW-1:0] pop_or_free;
    logic [MAX_WINDOW-1:0] kept;
    logic [MAX_WINDOW-1:0] prev_kept;
    logic                  overflow;
    logic [POS_W-1:0]      head_age;
    logic [MAX_WINDOW:0]   valid_inc;

    // entries popped from the back form a suffix; free cells count as popped
    assign pop_or_free = le | ~valid_q;
    assign overflow    = kept[MAX_WINDOW-1];

    genvar i;
    generate
        for (i = 0; i < MAX_WINDOW; i++)
        begin : g_cell
            cell_sel_t         sel;
            logic [KMER_W-1:0] nx_hash;
            logic [POS_W-1:0]  nx_pos;
            logic [KMER_W-1:0] nx_kmer;
            logic              nx_valid;

            assign kept[i] = valid_q[i] & ~(&pop_or_free[MAX_WINDOW-1:i]);

            if (i == 0)
            begin : g_first
                assign prev_kept[i] = 1'b1;
            end
            else
            begin : g_inner
                assign prev_kept[i] = kept[i-1];
            end

            if (i == MAX_WINDOW - 1)
            begin : g_top
                assign nx_hash  = '0;
                assign nx_pos   = '0;
                assign nx_kmer  = '0;
                assign nx_valid = 1'b0;
            end
            else
            begin : g_link
                assign nx_hash  = hash_q[i+1];
                assign nx_pos   = pos_q[i+1];
                assign nx_kmer  = kmer_q[i+1];
                assign nx_valid = valid_q[i+1];
            end

            always_comb
            begin
                sel = CELL_HOLD;
                if (ctrl.clear)
                    sel = CELL_EMPTY;
                else if (ctrl.push)
                begin
                    if (overflow)
                        sel = (i == MAX_WINDOW - 1) ? CELL_LOAD_NEW : CELL_TAKE_NEXT;
                    else if (kept[i])
                        sel = CELL_HOLD;
                    else if (prev_kept[i])
                        sel = CELL_LOAD_NEW;
                    else
                        sel = CELL_EMPTY;
                end
                else if (ctrl.shift)
                    sel = (i == MAX_WINDOW - 1) ? CELL_EMPTY : CELL_TAKE_NEXT;
            end

            kwm_cell #(
                .POS_W(POS_W)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .sel       (sel),
                .new_hash  (new_hash),
                .new_pos   (new_pos),
                .new_kmer  (new_kmer),
                .next_hash (nx_hash),
                .next_pos  (nx_pos),
                .next_kmer (nx_kmer),
                .next_valid(nx_valid),
                .cell_hash (hash_q[i]),
                .cell_pos  (pos_q[i]),
                .cell_kmer (kmer_q[i]),
                .cell_valid(valid_q[i]),
                .hash_le   (le[i])
            );
        end
    endgenerate

    // age of the oldest entry against the newest start, modulo position width
    assign head_age            = new_pos - pos_q[0];
    assign status.head_valid   = valid_q[0];
    assign status.head_expired = head_age >= POS_W'(win);
    assign head_pos            = pos_q[0];
    assign head_kmer           = kmer_q[0];

    assign valid_inc = {1'b0, valid_q} + (MAX_WINDOW + 1)'(1);

    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_inc & {1'b0, valid_q}) == '0)
        else $error("queue valid bits are not a prefix");

    a_push_fills_head: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.push && !ctrl.clear |=> valid_q[0])
        else $error("queue head empty after push");

endmodule

// ===== src/kmer_window_minimizer.sv =====
// channel   dir  handshake            payload
// s_*       in   s_tvalid / s_tready   tdata: base_code[1:0]; tlast: end_of_sequence
// m_*       out  m_tvalid / m_tready   tdata: seed_start, seed_end, seed_kmer; tlast: seed_last
// cfg_*     in   cfg_we (no wait)      cfg_index selects kmer_length or window_size
//
// an item arriving before its k-mer is complete is accepted without leaving ST_IDLE
// an item with a complete k-mer goes through accept, 7 hash rounds in the mix unit,
//   seeing the hash done, queue push, expiry check (one expired entry dropped at a
//   time), seed emit
// the emit cycle waits while the output register still holds an untaken seed
// reset clears all control state and queue valid bits at once, no clearing pass
module kmer_window_minimizer #(
    parameter int MAX_WINDOW    = 64,
    parameter int POSITION_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // base_code[1:0], zero filled
    input  logic [kwm_pkg::IN_TDATA_W-1:0] s_tdata,
    // end_of_sequence
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // seed_start, seed_end, seed_kmer from the lowest bit up, zero filled
    output logic [((2*POSITION_BITS+kwm_pkg::KMER_W+7)/8)*8-1:0] m_tdata,
    // seed_last
    output logic                          m_tlast,
    input  logic                          cfg_we,
    input  logic [kwm_pkg::REG_IDX_W-1:0]  cfg_index,
    input  logic [kwm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import kwm_pkg::*;

    localparam int POS_W      = POSITION_BITS;
    localparam int OUT_TDATA_W = ((2*POS_W + KMER_W + 7)/8)*8;
    localparam int WCAP_W     = $clog2(MAX_WINDOW + 1);
    localparam int WEFF_W     = (WCAP_W > WIN_W) ? WCAP_W : WIN_W;
    localparam int THR_W      = WEFF_W + 1;

    // configuration
    logic [KLEN_W-1:0] kmer_length_reg;
    logic [WIN_W-1:0]  window_size_reg;
    logic [KLEN_W-1:0] k_eff;
    logic [WEFF_W-1:0] w_eff;
    logic [KMER_W-1:0] kmer_mask;
    logic [THR_W-1:0]  seed_thr;

    // sequence state
    state_t            state_reg, state_next;
    logic [KMER_W-1:0] kmer_reg;
    logic [KMER_W-1:0] kmer_next;
    logic [POS_W-1:0]  base_count_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [POS_W-1:0]  last_seed_reg;
    logic              any_seed_reg;
    logic [POS_W-1:0]  start_reg;
    logic              eos_reg;

    // output register
    logic              out_valid_reg;
    logic [POS_W-1:0]  out_start_reg;
    logic [POS_W-1:0]  out_end_reg;
    logic [KMER_W-1:0] out_kmer_reg;
    logic              out_last_reg;

    // control
    logic              accept;
    logic              hash_start;
    logic              clear_seq;
    logic              emit_load;
    logic              emit_need;
    logic              slot_free;
    logic              kmer_enough;
    queue_ctrl_t       qctrl;
    queue_status_t     qstatus;
    logic [KMER_W-1:0] hash_value;
    logic              hash_done;
    logic [POS_W-1:0]  head_pos;
    logic [KMER_W-1:0] head_kmer;

    // zero lengths act as one, window saturates at the queue depth
    assign k_eff = (kmer_length_reg == '0) ? KLEN_W'(1) : kmer_length_reg;
    always_comb
    begin
        if (window_size_reg == '0)
            w_eff = WEFF_W'(1);
        else if (WEFF_W'(window_size_reg) > WEFF_W'(MAX_WINDOW))
            w_eff = WEFF_W'(MAX_WINDOW);
        else
            w_eff = WEFF_W'(window_size_reg);
    end

    // 2k low bits set; shifting by 62 clears the word so the mask is all ones
    assign kmer_mask = ~({KMER_W{1'b1}} << {k_eff, 1'b0});
    assign seed_thr  = THR_W'(k_eff) + THR_W'(w_eff) - THR_W'(1);

    assign kmer_next   = ((kmer_reg << BASE_W) | KMER_W'(s_tdata[BASE_W-1:0])) & kmer_mask;
    assign fill_next   = (fill_reg == FILL_CAP) ? fill_reg : fill_reg + FILL_W'(1);
    assign kmer_enough = fill_next >= FILL_W'(k_eff);

    assign s_tready  = state_reg == ST_IDLE;
    assign accept    = s_tvalid & s_tready;
    assign slot_free = !out_valid_reg || m_tready;

    // a seed once the first full window exists and its start moved
    assign emit_need = (THR_W'(fill_reg) >= seed_thr) && qstatus.head_valid
                       && (!any_seed_reg || head_pos != last_seed_reg);

    always_comb
    begin
        state_next  = state_reg;
        hash_start  = 1'b0;
        clear_seq   = 1'b0;
        emit_load   = 1'b0;
        qctrl       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (kmer_enough)
                    begin
                        hash_start = 1'b1;
                        state_next = ST_HASH;
                    end
                    else if (s_tlast)
                    begin
                        clear_seq   = 1'b1;
                        qctrl.clear = 1'b1;
                    end
                end
            end
            ST_HASH:
            begin
                if (hash_done)
                    state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                qctrl.push = 1'b1;
                state_next = ST_EXPIRE;
            end
            ST_EXPIRE:
            begin
                // drop one stale entry from the front per cycle
                if (qstatus.head_valid && qstatus.head_expired)
                    qctrl.shift = 1'b1;
                else
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!(emit_need && !slot_free))
                begin
                    emit_load = emit_need;
                    if (eos_reg)
                    begin
                        clear_seq   = 1'b1;
                        qctrl.clear = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_length_reg <= KLEN_RESET;
            window_size_reg <= WIN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KMER_LENGTH: kmer_length_reg <= cfg_data[KLEN_W-1:0];
                REG_WINDOW_SIZE: window_size_reg <= cfg_data[WIN_W-1:0];
            endcase
        end
    end

    // per-sequence state; the end item clears it after its own use
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_reg       <= '0;
            base_count_reg <= '0;
            fill_reg       <= '0;
            last_seed_reg  <= '0;
            any_seed_reg   <= 1'b0;
        end
        else if (clear_seq)
        begin
            kmer_reg       <= '0;
            base_count_reg <= '0;
            fill_reg       <= '0;
            last_seed_reg  <= '0;
            any_seed_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                kmer_reg       <= kmer_next;
                base_count_reg <= base_count_reg + POS_W'(1);
                fill_reg       <= fill_next;
            end
            if (emit_load)
            begin
                last_seed_reg <= head_pos;
                any_seed_reg  <= 1'b1;
            end
        end
    end

    // start of the k-mer ending at this base
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            start_reg <= base_count_reg - (POS_W'(k_eff) - POS_W'(1));
            eos_reg   <= s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            out_start_reg <= head_pos;
            out_end_reg   <= head_pos + POS_W'(k_eff) - POS_W'(1);
            out_kmer_reg  <= head_kmer;
            out_last_reg  <= eos_reg;
        end
    end

    kwm_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (kmer_next),
        .mask  (kmer_mask),
        .result(hash_value),
        .done  (hash_done)
    );

    kwm_queue #(
        .MAX_WINDOW(MAX_WINDOW),
        .POS_W     (POS_W),
        .WEFF_W    (WEFF_W)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (qctrl),
        .new_hash (hash_value),
        .new_pos  (start_reg),
        .new_kmer (kmer_reg),
        .win      (w_eff),
        .head_pos (head_pos),
        .head_kmer(head_kmer),
        .status   (qstatus)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({out_kmer_reg, out_end_reg, out_start_reg});
    assign m_tlast  = out_last_reg;

    a_hash_done_in_hash: assert property (@(posedge clk) disable iff (!rst_n)
        hash_done |-> state_reg == ST_HASH)
        else $error("hash finished outside hash state");

    a_seed_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg) == ST_EMIT)
        else $error("seed loaded outside emit state");

    a_seed_held: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("seed changed while stalled");

endmodule
